>>> rtl/assert_macros.svh
// Assertion macros for the keyword substitution decoder checkers.
// Used by files that assert; needs signals named i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define KWSD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kwsd check failed");

// Clocked check that also holds across reset.
`define KWSD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("kwsd reset check failed");

`endif

>>> rtl/kwsd_pkg.sv
// Package for the keyword substitution decoder: codes, constants and types.
// No dependencies.
package kwsd_pkg;

    localparam int TABLE_ENTRIES_DEF = 26;
    localparam int CNT_W             = 5;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_HALTED    = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Query word walking down the cell chain.
    typedef struct packed {
        logic             act;
        logic [7:0]       ch;
        logic             hit;
        logic [CNT_W-1:0] pos;
    } t_token;

    // Table write command broadcast to all cells.
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

endpackage

>>> rtl/kwsd_if.sv
// Valid/ready channel interfaces for the keyword substitution decoder.
// No dependencies.
interface kwsd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] character;

    modport source(output valid, output operation, output character, input ready);
    modport sink(input valid, input operation, input character, output ready);
endinterface

interface kwsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded;
    logic [1:0] status;
    logic       table_full;

    modport source(output valid, output decoded, output status, output table_full,
                   input ready);
    modport sink(input valid, input decoded, input status, input table_full,
                 output ready);
endinterface

>>> rtl/keyword_substitution_decoder_core.sv
// Keyword substitution decoder. A load or decode word is accepted, its query walks
// the row of table cells, and a commit step then updates the table and flags and
// fills the output register; the commit waits while an earlier result is still held.
// No new word is accepted until the current load or decode word has committed.
// A clear word gives no result; operation code three is dropped. A waiting result
// does not block acceptance of the next word.
module keyword_substitution_decoder_core
    import kwsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwsd_in_if.sink    i_in,
    kwsd_out_if.source o_out
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(TABLE_ENTRIES);

    t_state           r_state, n_state;
    logic [1:0]       r_op;
    logic [7:0]       r_ch;
    logic             r_hit;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_halted, n_halted;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_decoded, n_decoded;
    logic [1:0]       r_status, n_status;
    logic             r_full, n_full;

    logic   w_accept;
    logic   w_commit;
    t_token w_tok_in;
    t_token w_tok_out;
    t_wr    w_wr;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_tok_in.act = w_accept && ((i_in.operation == OP_LOAD) ||
                                    (i_in.operation == OP_DECODE));
        w_tok_in.ch  = i_in.character;
        w_tok_in.hit = 1'b0;
        w_tok_in.pos = '0;
    end

    kwsd_chain #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok_in),
        .i_count (r_count),
        .i_wr    (w_wr),
        .o_tok   (w_tok_out)
    );

    assign w_commit = (r_state == ST_FINISH) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_halted    = r_halted;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_decoded   = r_decoded;
        n_status    = r_status;
        n_full      = r_full;
        w_wr.en     = 1'b0;
        w_wr.data   = r_ch;

        case (r_state)
            ST_IDLE: begin
                if (w_tok_in.act) begin
                    n_state = ST_WALK;
                end else if (w_accept && (i_in.operation == OP_CLEAR)) begin
                    n_count  = '0;
                    n_halted = 1'b0;
                    n_ovf    = 1'b0;
                end
            end
            ST_WALK: begin
                if (w_tok_out.act) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_commit) begin
                    n_state   = ST_IDLE;
                    n_decoded = 8'h00;
                    n_status  = STAT_OK;
                    if (r_op == OP_LOAD) begin
                        if ((r_ch != CH_SPACE) && !r_hit) begin
                            if (r_count < MAX_CNT) begin
                                w_wr.en = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else if (r_halted) begin
                        n_status = STAT_HALTED;
                    end else if (r_ch == CH_SPACE) begin
                        n_decoded = CH_SPACE;
                    end else if (!r_hit) begin
                        n_status = STAT_NOT_FOUND;
                        n_halted = 1'b1;
                    end else begin
                        n_decoded = CH_LOWER_A + 8'(r_pos);
                    end
                    n_full      = n_ovf;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in.operation;
            r_ch <= i_in.character;
        end
        // Capture the match as the query leaves the last cell.
        if ((r_state == ST_WALK) && w_tok_out.act) begin
            r_hit <= w_tok_out.hit;
            r_pos <= w_tok_out.pos;
        end
        r_decoded <= n_decoded;
        r_status  <= n_status;
        r_full    <= n_full;
        if (!i_rst_n) begin
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.decoded    = r_decoded;
    assign o_out.status     = r_status;
    assign o_out.table_full = r_full;

endmodule

>>> rtl/kwsd_cell.sv
// One table cell: holds a key byte and checks the passing query word.
// Depends on kwsd_pkg.
module kwsd_cell
    import kwsd_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_token           i_tok,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr              i_wr,
    output t_token           o_tok
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [7:0] r_key;
    t_token     r_tok;
    t_token     n_tok;

    always_comb begin
        n_tok = i_tok;
        // Keys are distinct, so at most one cell can claim the query.
        if (i_tok.act && !i_tok.hit && (i_count > MY_IDX) && (r_key == i_tok.ch)) begin
            n_tok.hit = 1'b1;
            n_tok.pos = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_count == MY_IDX)) begin
            r_key <= i_wr.data;
        end
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_tok.act <= 1'b0;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> rtl/kwsd_chain.sv
// Row of table cells; the query word advances one cell per cycle.
// Depends on kwsd_pkg and kwsd_cell.
module kwsd_chain
    import kwsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_token           i_tok,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr              i_wr,
    output t_token           o_tok
);

    t_token w_tok [TABLE_ENTRIES+1];

    assign w_tok[0] = i_tok;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        kwsd_cell #(
            .INDEX(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[k]),
            .i_count (i_count),
            .i_wr    (i_wr),
            .o_tok   (w_tok[k+1])
        );
    end

    assign o_tok = w_tok[TABLE_ENTRIES];

endmodule

>>> rtl/kwsd_checker.sv
// Port-level checks for the keyword substitution decoder, bound to the top level.
// Depends on kwsd_pkg, assert_macros.svh and keyword_substitution_decoder_core.
`include "assert_macros.svh"

module kwsd_checker
    import kwsd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_operation,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_decoded,
    input logic [1:0] i_status,
    input logic       i_table_full
);

    logic [10:0] w_out_word;
    logic        w_walk_start;

    assign w_out_word   = {i_decoded, i_status, i_table_full};
    assign w_walk_start = i_in_valid && i_in_ready &&
                          ((i_in_operation == OP_LOAD) || (i_in_operation == OP_DECODE));

    // Hold a stalled result.
    `KWSD_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(w_out_word))

    // Drop the result after reset.
    `KWSD_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_out_valid)

    // An error result carries no plain byte.
    `KWSD_ASSERT(a_err_zero, i_out_valid && (i_status != STAT_OK) |-> i_decoded == 8'h00)

    // A load or decode word occupies the chain, so input stalls next cycle.
    `KWSD_ASSERT(a_walk_busy, w_walk_start |=> !i_in_ready)

endmodule

bind keyword_substitution_decoder_core kwsd_checker u_kwsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_decoded      (o_out.decoded),
    .i_status       (o_out.status),
    .i_table_full   (o_out.table_full)
);

>>> verif/keyword_substitution_decoder_core_tb.sv
// Self-checking testbench for keyword_substitution_decoder_core: a table of directed
// words, then random key/message episodes with bursty input and a stalling receiver.
// Depends on kwsd_pkg and the kwsd_in_if / kwsd_out_if channel interfaces.
module keyword_substitution_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kwsd_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_WORDS = 430;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         TAIL_CYCLES  = 80;
    localparam int         CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [7:0] decoded;
        logic [1:0] status;
        logic       table_full;
    } t_plain;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic       fixed;
        t_plain     expv;
    } t_word;

    localparam t_plain NO_RES = '{8'h00, STAT_OK, 1'b0};

    // Typed expectations only where they are obvious; the rest go to the predictor.
    localparam int N_DIRECTED = 22;
    localparam t_word DIRECTED [N_DIRECTED] = '{
        '{OP_DECODE, "x",      1'b1, '{8'h00, STAT_NOT_FOUND, 1'b0}},
        '{OP_DECODE, CH_SPACE, 1'b1, '{8'h00, STAT_HALTED, 1'b0}},
        '{OP_DECODE, 8'h00,    1'b1, '{8'h00, STAT_HALTED, 1'b0}},
        '{OP_LOAD,   "q",      1'b0, NO_RES},
        '{OP_CLEAR,  8'h00,    1'b0, NO_RES},
        '{OP_DECODE, CH_SPACE, 1'b1, '{CH_SPACE, STAT_OK, 1'b0}},
        '{OP_LOAD,   CH_SPACE, 1'b0, NO_RES},
        '{OP_LOAD,   8'hFF,    1'b0, NO_RES},
        '{OP_LOAD,   8'h00,    1'b0, NO_RES},
        '{OP_LOAD,   "k",      1'b0, NO_RES},
        '{OP_LOAD,   8'hFF,    1'b0, NO_RES},
        '{OP_DECODE, 8'hFF,    1'b1, '{CH_LOWER_A, STAT_OK, 1'b0}},
        '{OP_DECODE, 8'h00,    1'b0, NO_RES},
        '{OP_DECODE, "k",      1'b0, NO_RES},
        '{OP_UNUSED, 8'hAA,    1'b0, NO_RES},
        '{OP_DECODE, CH_SPACE, 1'b0, NO_RES},
        '{OP_DECODE, "z",      1'b1, '{8'h00, STAT_NOT_FOUND, 1'b0}},
        '{OP_LOAD,   "z",      1'b0, NO_RES},
        '{OP_DECODE, "z",      1'b1, '{8'h00, STAT_HALTED, 1'b0}},
        '{OP_CLEAR,  8'h55,    1'b0, NO_RES},
        '{OP_DECODE, "k",      1'b1, '{8'h00, STAT_NOT_FOUND, 1'b0}},
        '{OP_CLEAR,  8'h00,    1'b0, NO_RES}
    };

    logic i_clk;
    logic i_rst_n;

    kwsd_in_if  in_ch ();
    kwsd_out_if out_ch ();

    keyword_substitution_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state
    logic [7:0] key_bytes [TABLE_ENTRIES_DEF];
    int         key_count;
    bit         decode_halted;
    bit         key_overflow;

    t_word  word_plan [$];
    t_plain plain_q [$];

    int n_accepted;
    int error_count;
    int cycle_count;
    bit hold_done;
    int n_letters, n_spaces, n_missing, n_halted, n_full, n_clears, n_loads;

    always #2 i_clk = ~i_clk;

    function automatic void predict_plain(input logic [1:0] op, input logic [7:0] ch,
                                          output bit produced, output t_plain res);
        int pos;
        int p;
        res      = NO_RES;
        produced = 1'b0;
        pos      = -1;
        for (p = 0; p < key_count; p++) begin
            if (pos < 0 && key_bytes[p] == ch) pos = p;
        end
        case (op)
            OP_CLEAR: begin
                key_count     = 0;
                decode_halted = 1'b0;
                key_overflow  = 1'b0;
            end
            OP_LOAD: begin
                if (ch != CH_SPACE && pos < 0) begin
                    if (key_count < TABLE_ENTRIES_DEF) begin
                        key_bytes[key_count] = ch;
                        key_count++;
                    end else begin
                        key_overflow = 1'b1;
                    end
                end
                produced = 1'b1;
            end
            OP_DECODE: begin
                if (decode_halted) begin
                    res.status = STAT_HALTED;
                end else if (ch == CH_SPACE) begin
                    res.decoded = CH_SPACE;
                end else if (pos < 0) begin
                    res.status    = STAT_NOT_FOUND;
                    decode_halted = 1'b1;
                end else begin
                    res.decoded = CH_LOWER_A + 8'(pos);
                end
                produced = 1'b1;
            end
            default: ;
        endcase
        res.table_full = key_overflow;
    endfunction

    function automatic void add_word(input logic [1:0] op, input logic [7:0] ch);
        word_plan.push_back('{op, ch, 1'b0, NO_RES});
    endfunction

    // Episodes: clear (usually), load key phrase, decode a message mostly from it.
    task automatic build_random_part();
        logic [7:0] keys [$];
        logic [7:0] b;
        int         words;
        int         k_len, m_len, i, r;
        bit         first;
        words = 0;
        first = 1'b1;
        while (words < RANDOM_WORDS) begin
            if (first || $urandom_range(0, 9) != 0) begin
                add_word(OP_CLEAR, 8'($urandom));
                words++;
            end
            keys.delete();
            if (first) k_len = 32;
            else if ($urandom_range(0, 6) == 0) k_len = $urandom_range(20, 34);
            else k_len = $urandom_range(1, 10);
            for (i = 0; i < k_len; i++) begin
                r = $urandom_range(0, 9);
                if (r == 0) b = CH_SPACE;
                else if (r == 1 && keys.size() != 0) b = keys[$urandom_range(0, keys.size() - 1)];
                else b = 8'($urandom_range(0, 255));
                add_word(OP_LOAD, b);
                keys.push_back(b);
                words++;
            end
            m_len = $urandom_range(1, 16);
            for (i = 0; i < m_len; i++) begin
                r = $urandom_range(0, 24);
                if (r == 0) b = 8'($urandom_range(0, 255));
                else if (r < 5) b = CH_SPACE;
                else b = keys[$urandom_range(0, keys.size() - 1)];
                if (r == 23) begin
                    add_word(OP_UNUSED, b);
                end else if (r == 24) begin
                    add_word(OP_LOAD, b);
                    words++;
                end else begin
                    add_word(OP_DECODE, b);
                    words++;
                end
            end
            first = 1'b0;
        end
    endtask

    // Sample both channels at the rising edge: predict on input, check on output.
    always @(posedge i_clk) begin
        t_word  w;
        t_plain pred, got, want;
        bit     produced;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                w = word_plan[n_accepted];
                n_accepted++;
                predict_plain(in_ch.operation, in_ch.character, produced, pred);
                if (in_ch.operation == OP_CLEAR) n_clears++;
                if (produced) begin
                    want = w.fixed ? w.expv : pred;
                    plain_q.push_back(want);
                    if (in_ch.operation == OP_LOAD) n_loads++;
                    else if (want.status == STAT_NOT_FOUND) n_missing++;
                    else if (want.status == STAT_HALTED) n_halted++;
                    else if (want.decoded == CH_SPACE) n_spaces++;
                    else n_letters++;
                    if (want.table_full) n_full++;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.decoded, out_ch.status, out_ch.table_full};
                if (plain_q.size() == 0) begin
                    $display("%0t: unexpected result decoded %h status %0d table_full %0b",
                             $realtime, got.decoded, got.status, got.table_full);
                    error_count++;
                end else begin
                    want = plain_q.pop_front();
                    if (got.decoded !== want.decoded) begin
                        $display("%0t: decoded mismatch, expected %h actual %h",
                                 $realtime, want.decoded, got.decoded);
                        error_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                        error_count++;
                    end
                    if (got.table_full !== want.table_full) begin
                        $display("%0t: table_full mismatch, expected %0b actual %0b",
                                 $realtime, want.table_full, got.table_full);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words accepted, %0d results outstanding",
                     $realtime, n_accepted, plain_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall pattern that switches mode, plus one long hold-off.
    initial begin : receiver
        int mode, left, tick;
        out_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_accepted >= 60) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 150);
            end
            left--;
            tick++;
            case (mode)
                0:       out_ch.ready = 1'b1;
                1:       out_ch.ready = 1'($urandom_range(0, 1));
                2:       out_ch.ready = ($urandom_range(0, 4) == 0);
                default: out_ch.ready = (tick % 5 != 0);
            endcase
        end
    end

    initial begin : main
        int idx, burst, k, sel, gap;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_LOAD;
        in_ch.character = 8'h00;
        key_count       = 0;
        decode_halted   = 1'b0;
        key_overflow    = 1'b0;
        n_accepted      = 0;
        error_count     = 0;
        cycle_count     = 0;
        hold_done       = 1'b0;
        n_letters = 0; n_spaces = 0; n_missing = 0; n_halted = 0;
        n_full = 0; n_clears = 0; n_loads = 0;

        for (idx = 0; idx < N_DIRECTED; idx++) word_plan.push_back(DIRECTED[idx]);
        build_random_part();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Send in bursts; hold valid across a burst, drop it only for a gap.
        idx = 0;
        while (idx < word_plan.size()) begin
            burst = $urandom_range(1, 10);
            for (k = 0; k < burst && idx < word_plan.size(); k++) begin
                in_ch.valid     = 1'b1;
                in_ch.operation = word_plan[idx].op;
                in_ch.character = word_plan[idx].ch;
                do @(posedge i_clk); while (!in_ch.ready);
                @(negedge i_clk);
                idx++;
            end
            sel = $urandom_range(0, 3);
            if (sel == 0) gap = 0;
            else if (sel == 1) gap = $urandom_range(1, 4);
            else gap = $urandom_range(5, 70);
            if (gap > 0) begin
                in_ch.valid     = 1'b0;
                in_ch.operation = 2'($urandom);
                in_ch.character = 8'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        in_ch.valid = 1'b0;

        while (n_accepted < word_plan.size() || plain_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d words: %0d loads, %0d clears, %0d letters, %0d spaces decoded",
                 n_accepted, n_loads, n_clears, n_letters, n_spaces);
        $display("Missing bytes %0d, halted decodes %0d, results with table full %0d",
                 n_missing, n_halted, n_full);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
